/* hdl/assert_macros.svh */
// assertion macros used by the length core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, expr, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`endif

`endif

/* hdl/lpsc_pkg.sv */
// shared constants for the patience sort length core
package lpsc_pkg;

   // default table depth and value width
   localparam int DEF_MAX_PILES  = 1024;
   localparam int DEF_VALUE_BITS = 32;

endpackage

/* hdl/lpsc_tail_ram.sv */
// pile tail memory with one write port, one read port and registered read data
module lpsc_tail_ram #(
   parameter int DEPTH = lpsc_pkg::DEF_MAX_PILES,
   parameter int WIDTH = lpsc_pkg::DEF_VALUE_BITS,
   parameter int AW    = (lpsc_pkg::DEF_MAX_PILES > 1) ? $clog2(lpsc_pkg::DEF_MAX_PILES) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import lpsc_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lis_length_patience_sort_core.sv */
// top level of the longest increasing subsequence length core
//
// usage notes
//  - req channel: one signed value per item plus an end of sequence flag;
//    req_ready is high only while the core is idle
//  - rsp channel: one item per request with the current length, a final
//    flag echoing end of sequence and a sticky overflow flag
//  - each item runs a binary search over the pile tails held in a tail
//    memory with separate read and write ports; every probe issues the
//    address, then compares the registered read data, and an item takes
//    up to P = ceil(log2(piles + 1)) probes
//  - the one compare unit and the midpoint adder are reused by each
//    probe under a small sequencer; a new item is taken only after the
//    previous result has been loaded into the output register
//  - the output register lets the core accept the next item while a
//    result still waits; if the receiver stalls, the next result waits
//    in the write state until the register frees up
//  - reset clears the pile count, the overflow flag and the sequencer;
//    the tail memory is not cleared and needs no clearing pass
//  - an item with end of sequence set returns its result and then starts
//    a fresh sequence
`include "assert_macros.svh"

module lis_length_patience_sort_core #(
   parameter int MAX_PILES  = lpsc_pkg::DEF_MAX_PILES,
   parameter int VALUE_BITS = lpsc_pkg::DEF_VALUE_BITS,
   parameter int CNT_W      = $clog2(MAX_PILES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_end_of_sequence,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_lis_length,
   output logic                  rsp_final_res,
   output logic                  rsp_overflowed
);
   import lpsc_pkg::*;

   localparam int AW = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PILES);

   // sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic [CNT_W-1:0]             lo_ff, lo_in;
   logic [CNT_W-1:0]             hi_ff, hi_in;
   logic [AW-1:0]                mid_ff, mid_in;
   logic signed [VALUE_BITS-1:0] key_ff, key_in;
   logic                         last_ff, last_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]             rsp_len_ff, rsp_len_in;
   logic                         rsp_final_ff, rsp_final_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   // memory port
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [VALUE_BITS-1:0]        ram_rd_data;

   // shared search arithmetic
   logic [CNT_W:0]               mid_sum;
   logic [CNT_W-1:0]             mid_full;
   logic                         tail_less;
   logic                         append;
   logic                         full_drop;
   logic [CNT_W-1:0]             count_upd;
   logic                         ovf_upd;
   logic                         commit;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full  = mid_sum[CNT_W:1];
   assign tail_less = $signed(ram_rd_data) < key_ff;

   // search ended at lo: replace inside the table, append, or drop
   assign append    = (lo_ff == count_ff) && (count_ff != MAX_CNT);
   assign full_drop = (lo_ff == count_ff) && (count_ff == MAX_CNT);
   assign count_upd = append ? count_ff + CNT_W'(1) : count_ff;
   assign ovf_upd   = ovf_ff | full_drop;

   assign commit    = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ready);
   assign ram_wr_en = commit && (lo_ff != MAX_CNT);
   assign ram_rd_en = (state_ff == ST_ISSUE) && (lo_ff < hi_ff);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_value;
               last_in  = req_end_of_sequence;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_full[AW-1:0];
               state_in = ST_CMP;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_CMP: begin
            // read data of the probed tail is valid here
            if (tail_less) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = ST_ISSUE;
         end
         ST_WRITE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = count_upd;
               rsp_final_in = last_ff;
               rsp_ovf_in   = ovf_upd;
               count_in     = last_ff ? '0 : count_upd;
               ovf_in       = last_ff ? 1'b0 : ovf_upd;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      last_ff      <= last_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   lpsc_tail_ram #(
      .DEPTH (MAX_PILES),
      .WIDTH (VALUE_BITS),
      .AW    (AW)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (lo_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (mid_full[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lis_length = rsp_len_ff;
   assign rsp_final_res  = rsp_final_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // pile count never passes the table depth
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= MAX_CNT, "pile count above depth")

   // search window stays ordered and inside the filled part of the table
   `ASSERT_IMPLY(a_window, clock, reset, (state_ff == ST_ISSUE) || (state_ff == ST_CMP),
      (lo_ff <= hi_ff) && (hi_ff <= count_ff), "search window out of order")

   // probed entry lies inside the current window
   `ASSERT_IMPLY(a_probe, clock, reset, state_ff == ST_CMP,
      (CNT_W'(mid_ff) >= lo_ff) && (CNT_W'(mid_ff) < hi_ff), "probe outside window")

   // a dropped append only happens with a full table
   `ASSERT_IMPLY(a_ovf_full, clock, reset, ovf_ff, count_ff == MAX_CNT,
      "overflow flag without full table")

endmodule

/* bench/lis_length_checker.sv */
// checker for the patience sort length core: predicts each result and compares it
`timescale 1ns / 1ps

module lis_length_checker #(
   parameter int MAX_PILES  = lpsc_pkg::DEF_MAX_PILES,
   parameter int VALUE_BITS = lpsc_pkg::DEF_VALUE_BITS,
   parameter int CNT_W      = $clog2(MAX_PILES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_end_of_sequence,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [CNT_W-1:0]      rsp_lis_length,
   input  logic                  rsp_final_res,
   input  logic                  rsp_overflowed,
   output int                    fail_count,
   output int                    pending,
   output int                    seq_closed,
   output int                    ovf_results,
   output int                    peak_length
);

   typedef struct packed {
      logic [CNT_W-1:0] length;
      logic             closes;
      logic             dropped;
   } pile_report_type;

   logic signed [VALUE_BITS-1:0] pile_tails [MAX_PILES];
   int unsigned                  pile_depth;
   bit                           drop_sticky;
   pile_report_type              awaited_reports [$];

   // binary search for the first tail not less than the value, then replace, append, or drop when full
   task automatic place_on_pile(input logic signed [VALUE_BITS-1:0] v, input logic last,
                                output pile_report_type rep);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = pile_depth;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (pile_tails[mid] < v) lo = mid + 1;
         else hi = mid;
      end
      if (lo < pile_depth) begin
         pile_tails[lo] = v;
      end else if (pile_depth < MAX_PILES) begin
         pile_tails[pile_depth] = v;
         pile_depth++;
      end else begin
         drop_sticky = 1'b1;
      end
      rep.length  = CNT_W'(pile_depth);
      rep.closes  = last;
      rep.dropped = drop_sticky;
      if (last) begin
         pile_depth  = 0;
         drop_sticky = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      pile_report_type want;
      if (reset) begin
         pile_depth  = 0;
         drop_sticky = 1'b0;
         awaited_reports.delete();
         fail_count  <= 0;
         seq_closed  <= 0;
         ovf_results <= 0;
         peak_length <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_final_res) seq_closed <= seq_closed + 1;
            if (rsp_overflowed) ovf_results <= ovf_results + 1;
            if (rsp_lis_length > peak_length) peak_length <= rsp_lis_length;
            if (awaited_reports.size() == 0) begin
               $error("result with no item waiting: lis_length %0d", rsp_lis_length);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_lis_length !== want.length ||
                   rsp_final_res !== want.closes ||
                   rsp_overflowed !== want.dropped) begin
                  fail_count <= fail_count + 1;
               end
               if (rsp_lis_length !== want.length)
                  $error("lis_length: expected %0d, got %0d", want.length, rsp_lis_length);
               if (rsp_final_res !== want.closes)
                  $error("final_res: expected %0b, got %0b", want.closes, rsp_final_res);
               if (rsp_overflowed !== want.dropped)
                  $error("overflowed: expected %0b, got %0b", want.dropped, rsp_overflowed);
            end
         end
         if (req_valid && req_ready) begin
            place_on_pile($signed(req_value), req_end_of_sequence, want);
            awaited_reports = {awaited_reports, want};
         end
      end
      pending <= awaited_reports.size();
   end

endmodule

/* bench/lis_length_patience_sort_core_tb.sv */
// testbench top for the patience sort length core: stimulus, idling and verdict
`timescale 1ns / 1ps

module lis_length_patience_sort_core_tb;

   localparam int MAX_PILES  = lpsc_pkg::DEF_MAX_PILES;
   localparam int VALUE_BITS = lpsc_pkg::DEF_VALUE_BITS;
   localparam int CNT_W      = $clog2(MAX_PILES + 1);

   // most negative and most positive values
   localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   // random part size, the stall watchdog and the final drain
   localparam int RANDOM_ITEMS = 240;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_end_of_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CNT_W-1:0]      rsp_lis_length;
   logic                  rsp_final_res;
   logic                  rsp_overflowed;

   int  fail_count;
   int  pending;
   int  seq_closed;
   int  ovf_results;
   int  peak_length;
   int  items_sent = 0;
   int  idle_cycles = 0;
   int  ready_hold = 0;
   // when set the sender inserts no gaps
   bit  tx_calm = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lis_length_patience_sort_core #(
      .MAX_PILES (MAX_PILES),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_end_of_sequence(req_end_of_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lis_length     (rsp_lis_length),
      .rsp_final_res      (rsp_final_res),
      .rsp_overflowed     (rsp_overflowed)
   );

   lis_length_checker #(
      .MAX_PILES (MAX_PILES),
      .VALUE_BITS(VALUE_BITS)
   ) checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_end_of_sequence(req_end_of_sequence),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lis_length     (rsp_lis_length),
      .rsp_final_res      (rsp_final_res),
      .rsp_overflowed     (rsp_overflowed),
      .fail_count         (fail_count),
      .pending            (pending),
      .seq_closed         (seq_closed),
      .ovf_results        (ovf_results),
      .peak_length        (peak_length)
   );

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver side: runs of ready, stalls of random length, and long calm stretches
   always @(negedge clock) begin
      int r;
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 7);
         end else if (r < 97) begin
            rsp_ready  <= 1'b0;
            ready_hold <= pick_gap();
         end else begin
            rsp_ready  <= 1'b1;
            ready_hold <= $urandom_range(50, 200);
         end
      end
   end

   // watchdog: cycles without any item accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("status: fail");
            $finish;
         end
      end
   end

   // present one item at a falling edge, hold it until the rising edge that takes it
   task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic last);
      int gap;
      gap = tx_calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_value           <= v;
      req_end_of_sequence <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // one random sequence; the flavor decides how its values relate
   task automatic send_random_sequence();
      int                    seq_len;
      int                    flavor;
      int                    r;
      logic [VALUE_BITS-1:0] v;
      logic signed [VALUE_BITS-1:0] walk;
      r = $urandom_range(0, 9);
      if (r < 6) seq_len = $urandom_range(1, 12);
      else if (r < 9) seq_len = $urandom_range(13, 60);
      else seq_len = $urandom_range(61, 250);
      flavor  = $urandom_range(0, 4);
      tx_calm = ($urandom_range(0, 5) == 0);
      walk    = $signed(VALUE_BITS'($urandom_range(0, 2000))) - 1000;
      for (int i = 0; i < seq_len; i++) begin
         case (flavor)
            0: v = VALUE_BITS'($urandom);
            // narrow window, many equal values
            1: v = VALUE_BITS'($urandom_range(0, 16)) - 8;
            // mostly rising walk with dips
            2: begin
               walk = walk + $signed(VALUE_BITS'($urandom_range(0, 60))) - 15;
               v    = walk;
            end
            // mostly falling walk
            3: begin
               walk = walk - $signed(VALUE_BITS'($urandom_range(0, 60))) + 15;
               v    = walk;
            end
            default: begin
               r = $urandom_range(0, 5);
               case (r)
                  0: v = VAL_MIN;
                  1: v = VAL_MAX;
                  2: v = '1;
                  3: v = '0;
                  4: v = 1;
                  default: v = VALUE_BITS'($urandom);
               endcase
            end
         endcase
         send_item(v, i == seq_len - 1);
      end
   endtask

   initial begin
      logic signed [VALUE_BITS-1:0] ramp;
      int                           random_start;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-item sequences at both extremes
      send_item(VAL_MIN, 1'b1);
      send_item(VAL_MAX, 1'b1);
      // extremes, an equal value that must not lengthen, a replacement, then growth
      send_item(VAL_MIN, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item('1, 1'b0);
      send_item('0, 1'b0);
      send_item(1, 1'b1);
      // strictly falling: length stays one
      for (int i = 5; i >= 1; i--) send_item(i, i == 1);
      // repeated value
      send_item(7, 1'b0);
      send_item(7, 1'b0);
      send_item(7, 1'b1);
      // signed order across zero
      send_item(-5, 1'b0);
      send_item(3, 1'b0);
      send_item(-4, 1'b0);
      send_item(4, 1'b1);

      // fill the whole table with a strictly rising run that starts below zero
      ramp = -60_000_000 + $signed(VALUE_BITS'($urandom_range(0, 1000)));
      for (int i = 0; i < MAX_PILES; i++) begin
         send_item(ramp, 1'b0);
         ramp = ramp + $signed(VALUE_BITS'($urandom_range(1, 100000)));
      end
      // table full: append dropped, replacements still land, flag stays sticky
      send_item(VAL_MAX, 1'b0);
      send_item('0, 1'b0);
      send_item(VAL_MIN, 1'b0);
      send_item(ramp, 1'b0);
      send_item(VAL_MAX, 1'b1);
      // flag must be clear in the next sequence
      send_item(VAL_MAX, 1'b1);

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) send_random_sequence();
      tx_calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items in %0d sequences, longest length seen %0d",
               items_sent, seq_closed, peak_length);
      $display("%0d results carried the overflow flag, %0d mismatching results",
               ovf_results, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lpsc_pkg.sv
hdl/lpsc_tail_ram.sv
hdl/lis_length_patience_sort_core.sv
bench/lis_length_checker.sv
bench/lis_length_patience_sort_core_tb.sv
